// ===== rtl/ddlb_pkg.sv =====
// Shared constants and field types for the decimal digit sequencer.
package ddlb_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam int NUM_W   = 32;
  localparam int COUNT_W = 4;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 6;
  localparam int DIGIT_W = 4;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  // ceil(2^35 / 10); (v * DIV10_MAGIC) >> 35 equals v / 10 for any 32-bit v
  localparam logic [NUM_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  localparam logic [CODE_W-1:0] CODE_SPACE = 6'd32;
  localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;
  localparam logic [CODE_W-1:0] CODE_NINE  = 6'd57;

  localparam logic [BYTE_W-1:0] WIDE_FONT_HEIGHT = 8'd8;
  localparam logic [BYTE_W-1:0] WIDE_FONT_EXTRA  = 8'd2;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// ===== rtl/decimal_digits_leading_blank.sv =====
// Top level: decimal digit sequencer with leading-zero blanking on a stream interface.
//
// Accepts one number word and emits one word per digit position, most significant
// position first, with leading zeros shown as spaces and the least significant digit
// always shown. After acceptance each kept digit takes one pass through the shared
// divide-by-ten unit (a registered 32x32 reciprocal multiply, then the remainder
// step), so a word with digit_count n (saturated to 10) is ready for output after
// n passes and then streams n result words, one per cycle with out_tready high.
// in_tready is high only while the sequencer is idle; the last result may still
// wait in the output register then.
// A digit_count of zero produces no results.
module decimal_digits_leading_blank (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // number[31:0], digit_count[35:32], start_column[43:36], page_row[51:44],
  // font_height[59:52], zero[63:60]
  input  logic [ddlb_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // char_code[5:0], column[13:6], row_out[21:14], zero[23:22]
  output logic [ddlb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_t;

  state_t                              state_r;
  logic [ddlb_pkg::NUM_W-1:0]          value_r;
  logic [ddlb_pkg::COUNT_W-1:0]        cnt_r;
  logic [ddlb_pkg::IDX_W-1:0]          idx_r;
  logic [ddlb_pkg::BYTE_W-1:0]         col_r;
  logic [ddlb_pkg::BYTE_W-1:0]         step_r;
  logic [ddlb_pkg::BYTE_W-1:0]         row_r;
  logic                                shown_r;
  ddlb_pkg::digit_t                    digits_r [ddlb_pkg::MAX_DIGITS];

  logic                                out_valid_r;
  logic [ddlb_pkg::CODE_W-1:0]         out_code_r;
  logic [ddlb_pkg::BYTE_W-1:0]         out_col_r;
  logic [ddlb_pkg::BYTE_W-1:0]         out_row_r;
  logic                                out_last_r;

  logic [ddlb_pkg::NUM_W-1:0]          in_number;
  logic [ddlb_pkg::COUNT_W-1:0]        in_count;
  logic [ddlb_pkg::COUNT_W-1:0]        in_count_sat;
  logic [ddlb_pkg::BYTE_W-1:0]         in_col;
  logic [ddlb_pkg::BYTE_W-1:0]         in_row;
  logic [ddlb_pkg::BYTE_W-1:0]         in_height;
  logic [ddlb_pkg::BYTE_W-1:0]         in_step;

  logic [ddlb_pkg::NUM_W-1:0]          unit_quot;
  ddlb_pkg::digit_t                    unit_rem;

  logic                                in_fire;
  logic                                out_slot;
  logic                                emit_fire;
  ddlb_pkg::digit_t                    cur_digit;
  logic                                cur_last;
  logic                                cur_blank;
  logic [ddlb_pkg::CODE_W-1:0]         cur_code;

  ddlb_div10 u_div10 (
    .clk     (clk),
    .value_i (value_r),
    .quot_o  (unit_quot),
    .rem_o   (unit_rem)
  );

  assign in_number = in_tdata[31:0];
  assign in_count  = in_tdata[35:32];
  assign in_col    = in_tdata[43:36];
  assign in_row    = in_tdata[51:44];
  assign in_height = in_tdata[59:52];

  assign in_count_sat = (in_count > ddlb_pkg::COUNT_W'(ddlb_pkg::MAX_DIGITS)) ?
                        ddlb_pkg::COUNT_W'(ddlb_pkg::MAX_DIGITS) : in_count;
  assign in_step = {1'b0, in_height[ddlb_pkg::BYTE_W-1:1]} +
                   ((in_height == ddlb_pkg::WIDE_FONT_HEIGHT) ?
                    ddlb_pkg::WIDE_FONT_EXTRA : '0);

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_slot  = !out_valid_r || out_tready;
  assign emit_fire = (state_r == ST_EMIT) && out_slot;

  assign cur_digit = digits_r[idx_r];
  assign cur_last  = (idx_r == '0);
  assign cur_blank = !shown_r && !cur_last && (cur_digit == '0);
  assign cur_code  = cur_blank ? ddlb_pkg::CODE_SPACE :
                     ddlb_pkg::CODE_ZERO + {2'b00, cur_digit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            value_r <= in_number;
            cnt_r   <= in_count_sat;
            idx_r   <= '0;
            col_r   <= in_col;
            step_r  <= in_step;
            row_r   <= in_row;
            // drop a zero-count word at once
            if (in_count_sat != '0) begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          digits_r[idx_r] <= unit_rem;
          value_r         <= unit_quot;
          if (ddlb_pkg::COUNT_W'(idx_r) == cnt_r - 1'b1) begin
            shown_r <= 1'b0;
            state_r <= ST_EMIT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (out_slot) begin
            out_code_r  <= cur_code;
            out_col_r   <= col_r;
            out_row_r   <= row_r;
            out_last_r  <= cur_last;
            shown_r     <= shown_r || !cur_blank;
            col_r       <= col_r + step_r;
            if (cur_last) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_row_r, out_col_r, out_code_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_start_extract: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_count_sat != '0) |=> (state_r == ST_MUL))
    else $error("nonzero count did not start digit extraction");

  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (unit_rem < 4'd10))
    else $error("divide unit remainder out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cur_last && out_slot) |=>
      (out_tvalid && out_tlast && state_r == ST_IDLE))
    else $error("final digit did not end the run");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_code_r == ddlb_pkg::CODE_SPACE ||
                    (out_code_r >= ddlb_pkg::CODE_ZERO &&
                     out_code_r <= ddlb_pkg::CODE_NINE)))
    else $error("char code outside space and digits");
`endif

endmodule

// ===== rtl/ddlb_div10.sv =====
// Shared divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
module ddlb_div10 (
  input  logic                            clk,
  input  logic [ddlb_pkg::NUM_W-1:0]      value_i,
  output logic [ddlb_pkg::NUM_W-1:0]      quot_o,
  output ddlb_pkg::digit_t                rem_o
);

  logic [2*ddlb_pkg::NUM_W-1:0] prod_r;
  logic [ddlb_pkg::NUM_W-1:0]   times_ten;
  logic [ddlb_pkg::NUM_W-1:0]   diff;

  // value_i must stay put for the cycle after the product is taken
  always_ff @(posedge clk) begin
    prod_r <= {{ddlb_pkg::NUM_W{1'b0}}, value_i} *
              {{ddlb_pkg::NUM_W{1'b0}}, ddlb_pkg::DIV10_MAGIC};
  end

  assign quot_o = {3'b000, prod_r[2*ddlb_pkg::NUM_W-1:ddlb_pkg::DIV10_SHIFT]};

  assign times_ten = {quot_o[ddlb_pkg::NUM_W-4:0], 3'b000} +
                     {quot_o[ddlb_pkg::NUM_W-2:0], 1'b0};
  assign diff      = value_i - times_ten;
  assign rem_o     = diff[ddlb_pkg::DIGIT_W-1:0];

endmodule
